>>> sv/ppv_pkg.sv
// Package: types, widths and register codes of the point projection unit.
`default_nettype none
package ppv_pkg;

  localparam int COORD_WIDTH = 24;
  localparam int ENTRY_WIDTH = 16;
  localparam int FRAC_BITS   = 8;

  localparam int ROW_W  = 64;
  localparam int SIZE_W = 16;
  localparam int PIX_W  = 32;
  localparam int IDX_W  = 3;

  // One product of a matrix entry and a coordinate.
  localparam int PROD_W = ENTRY_WIDTH + COORD_WIDTH;
  // Row sum: three products plus the translation term, with headroom.
  localparam int SUM_W  = PROD_W + 3;
  // Dividend: row sum scaled by one in fixed point.
  localparam int NUM_W  = SUM_W + FRAC_BITS;
  // Quotient magnitude bits, one more than the pixel width for saturation.
  localparam int Q_W    = PIX_W + 1;
  // Partial remainder, wide enough to hold the shifted divisor.
  localparam int REM_W  = NUM_W + Q_W;

  typedef enum logic [IDX_W-1:0] {
    REG_ROW_0  = 3'd0,
    REG_ROW_1  = 3'd1,
    REG_ROW_2  = 3'd2,
    REG_WIDTH  = 3'd3,
    REG_HEIGHT = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic signed [COORD_WIDTH-1:0] point_z;
  } in_t;

  typedef struct packed {
    logic signed [PIX_W-1:0] pixel_col;
    logic signed [PIX_W-1:0] pixel_row;
    logic                    inside_res;
    logic                    degenerate;
  } out_t;

  // State of both divisions as it travels down the divider.
  typedef struct packed {
    logic             vld;
    logic [REM_W-1:0] rem_col;
    logic [REM_W-1:0] rem_row;
    logic [Q_W-1:0]   q_col;
    logic [Q_W-1:0]   q_row;
    logic [SUM_W-1:0] dvs;
    logic             neg_col;
    logic             neg_row;
    logic             ovf_col;
    logic             ovf_row;
    logic             degen;
  } div_t;

endpackage
`default_nettype wire

>>> sv/ppv_row_sum.sv
// One matrix row times the homogeneous point: products, then their sum.
`default_nettype none
module ppv_row_sum
  import ppv_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    en,
  input  wire logic [ROW_W-1:0]        row,
  input  wire in_t                     pnt,
  output logic signed [SUM_W-1:0]      sum_o
);

  logic signed [PROD_W-1:0] p0_r, p1_r, p2_r;
  logic signed [PROD_W-1:0] p0_nxt, p1_nxt, p2_nxt;
  logic signed [SUM_W-1:0]  t_r, t_nxt;
  logic signed [SUM_W-1:0]  sum_r, sum_nxt;
  logic signed [ENTRY_WIDTH-1:0] e0, e1, e2, e3;

  always_comb begin
    e0 = signed'(row[0*ENTRY_WIDTH +: ENTRY_WIDTH]);
    e1 = signed'(row[1*ENTRY_WIDTH +: ENTRY_WIDTH]);
    e2 = signed'(row[2*ENTRY_WIDTH +: ENTRY_WIDTH]);
    e3 = signed'(row[3*ENTRY_WIDTH +: ENTRY_WIDTH]);
    p0_nxt = PROD_W'(e0 * pnt.point_x);
    p1_nxt = PROD_W'(e1 * pnt.point_y);
    p2_nxt = PROD_W'(e2 * pnt.point_z);
    // The fourth coordinate is one in fixed point.
    t_nxt  = SUM_W'(e3) <<< FRAC_BITS;
    sum_nxt = SUM_W'(p0_r) + SUM_W'(p1_r) + SUM_W'(p2_r) + t_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p0_r  <= p0_nxt;
      p1_r  <= p1_nxt;
      p2_r  <= p2_nxt;
      t_r   <= t_nxt;
      sum_r <= sum_nxt;
    end
  end

  assign sum_o = sum_r;

endmodule
`default_nettype wire

>>> sv/ppv_div_step.sv
// One restoring division step for both coordinates, one quotient bit each.
`default_nettype none
module ppv_div_step
  import ppv_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic en,
  input  wire div_t st_i,
  output div_t      st_o
);

  div_t             st_r, st_nxt;
  logic [REM_W-1:0] dsh;
  logic [REM_W-1:0] dc, dr;
  logic             bc, br;

  always_comb begin
    dsh = REM_W'(st_i.dvs) << (Q_W - 1);
    bc  = st_i.rem_col >= dsh;
    br  = st_i.rem_row >= dsh;
    dc  = bc ? st_i.rem_col - dsh : st_i.rem_col;
    dr  = br ? st_i.rem_row - dsh : st_i.rem_row;
    st_nxt         = st_i;
    st_nxt.rem_col = dc << 1;
    st_nxt.rem_row = dr << 1;
    st_nxt.q_col   = {st_i.q_col[Q_W-2:0], bc};
    st_nxt.q_row   = {st_i.q_row[Q_W-2:0], br};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.vld <= 1'b0;
    end else if (en) begin
      st_r <= st_nxt;
    end
  end

  assign st_o = st_r;

endmodule
`default_nettype wire

>>> sv/point_projection_visibility_unit.sv
// Top level of the pinhole projection and visibility unit.
`default_nettype none
// Projects a signed fixed-point 3D point through a 3x4 homogeneous matrix
// and returns the pixel column and row in signed fixed point, saturated to
// 32 bits, with a flag for a point strictly inside the image and a flag for
// a zero depth sum (coordinates then read as zero). The unit is a pipeline
// of Q_W + 4 stages (37 at the default widths): two for the products and
// row sums, one to take magnitudes and check for overflow, one per quotient
// bit in the restoring divider, and one for sign, saturation and the image
// bounds test. A new request is taken in every cycle unless the output
// stalls: the whole pipeline holds while a result waits on out_ready, so
// nothing is dropped or repeated. Matrix rows and the image size are
// written through the cfg port and should only change while no request is
// in flight; writes to unknown indexes are ignored.
module point_projection_visibility_unit
  import ppv_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire in_t              in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output out_t                  out_data,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [IDX_W-1:0] cfg_index,
  input  wire logic [ROW_W-1:0] cfg_data
);

  localparam logic signed [PIX_W-1:0] PIX_MAX = {1'b0, {(PIX_W-1){1'b1}}};
  localparam logic signed [PIX_W-1:0] PIX_MIN = {1'b1, {(PIX_W-1){1'b0}}};
  localparam logic [Q_W-1:0] HALF = Q_W'(1) << (PIX_W - 1);

  // Configuration registers.
  logic [ROW_W-1:0]  row0_r, row1_r, row2_r;
  logic [SIZE_W-1:0] width_r, height_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row0_r   <= '0;
      row1_r   <= '0;
      row2_r   <= '0;
      width_r  <= SIZE_W'(640);
      height_r <= SIZE_W'(480);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ROW_0:  row0_r   <= cfg_data;
        REG_ROW_1:  row1_r   <= cfg_data;
        REG_ROW_2:  row2_r   <= cfg_data;
        REG_WIDTH:  width_r  <= cfg_data[SIZE_W-1:0];
        REG_HEIGHT: height_r <= cfg_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // The whole pipeline moves together unless the output request is stalled.
  logic adv;
  logic out_valid_r;
  out_t out_r, out_nxt;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  // Stages one and two: products and row sums.
  logic v1_r, v2_r;
  logic signed [SUM_W-1:0] s0, s1, s2;

  ppv_row_sum u_sum0 (.clk(clk), .en(adv), .row(row0_r), .pnt(in_data), .sum_o(s0));
  ppv_row_sum u_sum1 (.clk(clk), .en(adv), .row(row1_r), .pnt(in_data), .sum_o(s1));
  ppv_row_sum u_sum2 (.clk(clk), .en(adv), .row(row2_r), .pnt(in_data), .sum_o(s2));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  // Stage three: signed dividends to magnitudes, and the overflow check.
  // A quotient of Q_W bits or more saturates in any case, so the divider
  // only has to resolve the low Q_W bits.
  logic signed [NUM_W-1:0] n0, n1;
  logic [NUM_W-1:0] m0, m1;
  logic [SUM_W-1:0] md;
  logic [REM_W-1:0] lim;
  div_t div_in;

  always_comb begin
    n0  = {s0, {FRAC_BITS{1'b0}}};
    n1  = {s1, {FRAC_BITS{1'b0}}};
    m0  = n0[NUM_W-1] ? NUM_W'(-n0) : NUM_W'(n0);
    m1  = n1[NUM_W-1] ? NUM_W'(-n1) : NUM_W'(n1);
    md  = s2[SUM_W-1] ? SUM_W'(-s2) : SUM_W'(s2);
    lim = REM_W'(md) << Q_W;
    div_in.vld     = v2_r;
    div_in.rem_col = REM_W'(m0);
    div_in.rem_row = REM_W'(m1);
    div_in.q_col   = '0;
    div_in.q_row   = '0;
    div_in.dvs     = md;
    div_in.neg_col = n0[NUM_W-1] ^ s2[SUM_W-1];
    div_in.neg_row = n1[NUM_W-1] ^ s2[SUM_W-1];
    div_in.ovf_col = REM_W'(m0) >= lim;
    div_in.ovf_row = REM_W'(m1) >= lim;
    div_in.degen   = (s2 == '0);
  end

  div_t pipe [0:Q_W];
  div_t prep_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prep_r.vld <= 1'b0;
    end else if (adv) begin
      prep_r <= div_in;
    end
  end

  assign pipe[0] = prep_r;

  for (genvar k = 0; k < Q_W; k++) begin : g_div
    ppv_div_step u_step (
      .clk(clk), .rst_n(rst_n), .en(adv), .st_i(pipe[k]), .st_o(pipe[k+1])
    );
  end

  // Final stage: restore sign, saturate, test against the image bounds.
  function automatic logic signed [PIX_W-1:0] apply_sign(
    input logic [Q_W-1:0] mag, input logic ovf, input logic neg);
    logic signed [PIX_W-1:0] res;
    if (!neg) begin
      res = (ovf || mag >= HALF) ? PIX_MAX : signed'(mag[PIX_W-1:0]);
    end else begin
      res = (ovf || mag > HALF) ? PIX_MIN : signed'(PIX_W'(-mag[PIX_W-1:0]));
    end
    return res;
  endfunction

  div_t fin;
  logic signed [PIX_W-1:0] col, row, wlim, hlim;

  always_comb begin
    fin  = pipe[Q_W];
    col  = apply_sign(fin.q_col, fin.ovf_col, fin.neg_col);
    row  = apply_sign(fin.q_row, fin.ovf_row, fin.neg_row);
    wlim = signed'(PIX_W'(width_r) << FRAC_BITS);
    hlim = signed'(PIX_W'(height_r) << FRAC_BITS);
    if (fin.degen) begin
      out_nxt.pixel_col  = '0;
      out_nxt.pixel_row  = '0;
      out_nxt.inside_res = 1'b0;
    end else begin
      out_nxt.pixel_col  = col;
      out_nxt.pixel_row  = row;
      out_nxt.inside_res = (col > 0) && (col < wlim) && (row > 0) && (row < hlim);
    end
    out_nxt.degenerate = fin.degen;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= fin.vld;
      out_r       <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTH
  // A degenerate result carries zero coordinates and is never inside.
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.degenerate |->
      out_data.pixel_col == '0 && out_data.pixel_row == '0 && !out_data.inside_res)
    else $error("degenerate result with non-zero fields");

  // An inside result has strictly positive coordinates.
  a_inside_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.inside_res |->
      out_data.pixel_col > 0 && out_data.pixel_row > 0)
    else $error("inside result with non-positive coordinate");

  // A stalled result is held by the output register.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");
`endif

endmodule
`default_nettype wire
